### hw/rtl/msas_pkg.sv
// shared types and constants of the scan acquisition sequencer
// no dependencies; imported by msas_core and the top level

package msas_pkg;

    // fixed field widths
    localparam int WORD_W   = 64;
    localparam int COUNT_W  = 32;
    localparam int ACTIVE_W = 4;
    localparam int CMD_W    = 3;
    localparam int REASON_W = 2;
    localparam int CFG_IDX_W = 2;

    // parameter defaults
    localparam int MAX_CHANNELS_DEF = 14;
    localparam int CHANNEL_BITS_DEF = 4;
    localparam int SYNC_PERIOD_DEF  = 10;

    typedef enum logic [CMD_W-1:0] {
        CMD_NONE    = 3'd0,
        CMD_TRIGGER = 3'd1,
        CMD_HIRES   = 3'd2,
        CMD_RANGE   = 3'd3,
        CMD_CHANNEL = 3'd4
    } cmd_t;

    typedef enum logic [REASON_W-1:0] {
        STOP_NONE     = 2'd0,
        STOP_LIMIT    = 2'd1,
        STOP_CHAN_ERR = 2'd2,
        STOP_CHAN_MIS = 2'd3
    } stop_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HIRES  = 2'd0,
        CFG_LIMIT  = 2'd1,
        CFG_ACTIVE = 2'd2,
        CFG_SCAN   = 2'd3
    } cfg_idx_t;

    typedef enum logic [4:0] {
        PH_STOPPED   = 5'b00001,
        PH_TRIGGERED = 5'b00010,
        PH_HIRES     = 5'b00100,
        PH_RANGE     = 5'b01000,
        PH_CHANSYNC  = 5'b10000
    } phase_t;

    // fixed-width configuration handed to the sequencer core
    typedef struct packed {
        logic                hires_enabled;
        logic [COUNT_W-1:0]  sample_limit;
        logic [ACTIVE_W-1:0] active_channel_count;
    } cfg_t;

    // one result as computed by the core
    typedef struct packed {
        cmd_t              cmd;
        logic              sample_valid;
        logic [WORD_W-1:0] base_word;
        logic [WORD_W-1:0] hires_word;
        logic [WORD_W-1:0] range_word;
        logic              stopped;
        stop_t             reason;
    } res_t;

endpackage

### hw/rtl/msas_core.sv
// sequencer state registers and the single-pass step logic
// depends on msas_pkg

module msas_core #(
    parameter int MAX_CHANNELS = msas_pkg::MAX_CHANNELS_DEF,
    parameter int CHANNEL_BITS = msas_pkg::CHANNEL_BITS_DEF,
    parameter int SYNC_PERIOD  = msas_pkg::SYNC_PERIOD_DEF,
    localparam int SCAN_W      = MAX_CHANNELS * CHANNEL_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic                          op,
    input  logic                          reply_ok,
    input  logic [msas_pkg::WORD_W-1:0]   reply_value,
    input  logic [CHANNEL_BITS-1:0]       reply_channel,
    input  msas_pkg::cfg_t                cfg,
    input  logic [SCAN_W-1:0]             scan_list,
    output msas_pkg::res_t                res,
    output logic [CHANNEL_BITS-1:0]       sample_channel
);

    import msas_pkg::*;

    localparam int POS_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int SYNC_W = $clog2(SYNC_PERIOD);
    localparam int CMP_W  = ACTIVE_W + POS_W + 1;
    localparam logic [CMP_W-1:0]  MAX_N     = CMP_W'(MAX_CHANNELS);
    localparam logic [SYNC_W-1:0] SYNC_LAST = SYNC_W'(SYNC_PERIOD - 1);

    phase_t              phase_reg, phase_next;
    logic [WORD_W-1:0]   base_reg, base_next;
    logic [WORD_W-1:0]   hires_reg, hires_next;
    logic [WORD_W-1:0]   range_reg, range_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [SYNC_W-1:0]   sync_reg, sync_next;
    stop_t               reason_reg, reason_next;

    logic [CMP_W-1:0]        n_eff;
    logic [CMP_W-1:0]        active_ext;
    logic [POS_W-1:0]        pos_adv;
    logic [CHANNEL_BITS-1:0] chan_cur;
    logic [COUNT_W-1:0]      count_inc;
    logic [SYNC_W-1:0]       sync_inc;
    logic                    limit_new;
    logic                    limit_cur;

    // effective channel count: zero acts as one, clipped to the list size
    assign active_ext = CMP_W'(cfg.active_channel_count);
    assign n_eff = (active_ext == '0) ? CMP_W'(1) :
                   (active_ext > MAX_N) ? MAX_N : active_ext;

    assign pos_adv = ((CMP_W'(pos_reg) + CMP_W'(1)) >= n_eff) ? '0 : pos_reg + 1'b1;

    assign chan_cur = (int'(pos_reg) < MAX_CHANNELS) ?
                      scan_list[pos_reg*CHANNEL_BITS +: CHANNEL_BITS] : '0;

    assign count_inc = (count_reg == '1) ? count_reg : count_reg + 1'b1;
    assign sync_inc  = (sync_reg == SYNC_LAST) ? '0 : sync_reg + 1'b1;
    assign limit_new = (cfg.sample_limit != '0) && (count_inc >= cfg.sample_limit);
    assign limit_cur = (cfg.sample_limit != '0) && (count_reg >= cfg.sample_limit);

    always_comb
    begin
        phase_next  = phase_reg;
        base_next   = base_reg;
        hires_next  = hires_reg;
        range_next  = range_reg;
        pos_next    = pos_reg;
        count_next  = count_reg;
        sync_next   = sync_reg;
        reason_next = reason_reg;
        res.cmd          = CMD_NONE;
        res.sample_valid = 1'b0;
        res.base_word    = '0;
        res.hires_word   = '0;
        res.range_word   = '0;
        sample_channel   = '0;

        if (op)
        begin
            count_next  = '0;
            sync_next   = '0;
            pos_next    = '0;
            reason_next = STOP_NONE;
            phase_next  = PH_TRIGGERED;
            res.cmd     = CMD_TRIGGER;
        end
        else
        begin
            unique case (phase_reg)
                PH_STOPPED:
                begin
                    phase_next = PH_STOPPED;
                end
                PH_TRIGGERED:
                begin
                    if (!reply_ok)
                    begin
                        res.cmd = CMD_TRIGGER;
                    end
                    else
                    begin
                        base_next = reply_value;
                        if (cfg.hires_enabled)
                        begin
                            phase_next = PH_HIRES;
                            res.cmd    = CMD_HIRES;
                        end
                        else
                        begin
                            hires_next = '0;
                            phase_next = PH_RANGE;
                            res.cmd    = CMD_RANGE;
                        end
                    end
                end
                PH_HIRES:
                begin
                    if (!reply_ok)
                    begin
                        phase_next = PH_TRIGGERED;
                        res.cmd    = CMD_TRIGGER;
                    end
                    else
                    begin
                        hires_next = reply_value;
                        phase_next = PH_RANGE;
                        res.cmd    = CMD_RANGE;
                    end
                end
                PH_RANGE:
                begin
                    if (!reply_ok)
                    begin
                        phase_next = PH_TRIGGERED;
                        res.cmd    = CMD_TRIGGER;
                    end
                    else
                    begin
                        range_next       = reply_value;
                        res.sample_valid = 1'b1;
                        res.base_word    = base_reg;
                        res.hires_word   = hires_reg;
                        res.range_word   = reply_value;
                        sample_channel   = chan_cur;
                        count_next       = count_inc;
                        sync_next        = sync_inc;
                        if (limit_new)
                        begin
                            phase_next  = PH_STOPPED;
                            reason_next = STOP_LIMIT;
                        end
                        else
                        begin
                            pos_next = pos_adv;
                            if (sync_inc == SYNC_LAST && n_eff > CMP_W'(1))
                            begin
                                phase_next = PH_CHANSYNC;
                                res.cmd    = CMD_CHANNEL;
                            end
                            else
                            begin
                                phase_next = PH_TRIGGERED;
                                res.cmd    = CMD_TRIGGER;
                            end
                        end
                    end
                end
                PH_CHANSYNC:
                begin
                    priority if (!reply_ok)
                    begin
                        phase_next  = PH_STOPPED;
                        reason_next = STOP_CHAN_ERR;
                    end
                    else if (reply_channel != chan_cur)
                    begin
                        phase_next  = PH_STOPPED;
                        reason_next = STOP_CHAN_MIS;
                    end
                    else if (limit_cur)
                    begin
                        phase_next  = PH_STOPPED;
                        reason_next = STOP_LIMIT;
                    end
                    else
                    begin
                        phase_next = PH_TRIGGERED;
                        res.cmd    = CMD_TRIGGER;
                    end
                end
                default:
                begin
                    phase_next = PH_STOPPED;
                end
            endcase
        end

        res.stopped = (phase_next == PH_STOPPED);
        res.reason  = reason_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_STOPPED;
            base_reg   <= '0;
            hires_reg  <= '0;
            range_reg  <= '0;
            pos_reg    <= '0;
            count_reg  <= '0;
            sync_reg   <= '0;
            reason_reg <= STOP_NONE;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            base_reg   <= base_next;
            hires_reg  <= hires_next;
            range_reg  <= range_next;
            pos_reg    <= pos_next;
            count_reg  <= count_next;
            sync_reg   <= sync_next;
            reason_reg <= reason_next;
        end
    end

`ifndef SYNTHESIS
    a_start_rearms: assert property (@(posedge clk) disable iff (!rst_n)
        step && op |=> phase_reg == PH_TRIGGERED && count_reg == '0 && sync_reg == '0)
        else $error("start beat did not rearm the sequencer");

    a_stop_no_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        res.stopped == (res.cmd == CMD_NONE))
        else $error("stopped flag and issued command disagree");

    a_sample_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        res.sample_valid |-> (res.cmd == CMD_TRIGGER || res.cmd == CMD_CHANNEL
                              || res.cmd == CMD_NONE))
        else $error("sample emitted with a read command");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(pos_reg) < MAX_CHANNELS)
        else $error("scan position beyond the scan list");

    a_reason_on_stop: assert property (@(posedge clk) disable iff (!rst_n)
        step && !op && phase_reg != PH_STOPPED && phase_next == PH_STOPPED
        |-> reason_next != STOP_NONE)
        else $error("stop without a reason");
`endif

endmodule

### hw/rtl/meter_scan_acquisition_sequencer.sv
// top level of the scan acquisition sequencer: configuration registers,
// input beat register and result register around msas_core; uses msas_pkg

// The block takes one beat per clock cycle on its input while not stalled and
// gives exactly one result beat for each: the beat is first captured in an
// input register, then the single-pass step logic in msas_core updates the
// sequencer state and loads the result register. The sustained rate of one
// beat per cycle is set by that one step in msas_core; a stall on the
// output holds the result register and, through it, stalls the input only when
// both registers are full. A start beat (op = 1) arms the sequencer and issues
// a trigger; reply beats walk through base reading, optional high-resolution
// word and range, emitting each complete sample with its scan channel.
// Configuration is written through cfg_write_en / cfg_index / cfg_data and
// should only be changed while no beat is in flight.

module meter_scan_acquisition_sequencer #(
    parameter int MAX_CHANNELS = msas_pkg::MAX_CHANNELS_DEF,
    parameter int CHANNEL_BITS = msas_pkg::CHANNEL_BITS_DEF,
    parameter int SYNC_PERIOD  = msas_pkg::SYNC_PERIOD_DEF,
    localparam int SCAN_W      = MAX_CHANNELS * CHANNEL_BITS,
    localparam int CFG_DW      = (SCAN_W > msas_pkg::COUNT_W) ? SCAN_W : msas_pkg::COUNT_W
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration write port
    input  logic                             cfg_write_en,
    input  logic [msas_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DW-1:0]                cfg_data,
    // input channel
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             op,
    input  logic                             reply_ok,
    input  logic [msas_pkg::WORD_W-1:0]      reply_value,
    input  logic [CHANNEL_BITS-1:0]          reply_channel,
    // result channel
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [msas_pkg::CMD_W-1:0]       next_command,
    output logic                             sample_valid,
    output logic [msas_pkg::WORD_W-1:0]      sample_base,
    output logic [msas_pkg::WORD_W-1:0]      sample_hires,
    output logic [msas_pkg::WORD_W-1:0]      sample_range,
    output logic [CHANNEL_BITS-1:0]          sample_channel,
    output logic                             stopped,
    output logic [msas_pkg::REASON_W-1:0]    stop_reason
);

    import msas_pkg::*;

    // configuration registers
    logic                cfg_hires_reg;
    logic [COUNT_W-1:0]  cfg_limit_reg;
    logic [ACTIVE_W-1:0] cfg_active_reg;
    logic [SCAN_W-1:0]   cfg_scan_reg;
    cfg_t                cfg;

    // input beat register
    logic                    in_vld_reg, in_vld_next;
    logic                    in_op_reg;
    logic                    in_ok_reg;
    logic [WORD_W-1:0]       in_value_reg;
    logic [CHANNEL_BITS-1:0] in_chan_reg;

    // result register
    logic                    out_vld_reg, out_vld_next;
    res_t                    res_reg;
    logic [CHANNEL_BITS-1:0] res_chan_reg;

    res_t                    res;
    logic [CHANNEL_BITS-1:0] res_chan;
    logic                    out_free;
    logic                    step;
    logic                    in_take;

    // configuration writes, decoded by register index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_hires_reg  <= 1'b0;
            cfg_limit_reg  <= '0;
            cfg_active_reg <= ACTIVE_W'(1);
            cfg_scan_reg   <= '0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_HIRES:  cfg_hires_reg  <= cfg_data[0];
                CFG_LIMIT:  cfg_limit_reg  <= cfg_data[COUNT_W-1:0];
                CFG_ACTIVE: cfg_active_reg <= cfg_data[ACTIVE_W-1:0];
                CFG_SCAN:   cfg_scan_reg   <= cfg_data[SCAN_W-1:0];
                default:    cfg_hires_reg  <= cfg_hires_reg;
            endcase
        end
    end

    assign cfg.hires_enabled        = cfg_hires_reg;
    assign cfg.sample_limit         = cfg_limit_reg;
    assign cfg.active_channel_count = cfg_active_reg;

    // the result register frees up when empty or when its beat is taken
    assign out_free = !out_vld_reg || !out_stall;
    // a captured beat steps the sequencer once the result register can take it
    assign step     = in_vld_reg && out_free;
    // the input register holds only while its beat cannot move on
    assign in_stall = in_vld_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (in_take)
        begin
            in_vld_next = 1'b1;
        end
        else if (step)
        begin
            in_vld_next = 1'b0;
        end
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (step)
        begin
            out_vld_next = 1'b1;
        end
        else if (out_vld_reg && !out_stall)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_op_reg    <= op;
            in_ok_reg    <= reply_ok;
            in_value_reg <= reply_value;
            in_chan_reg  <= reply_channel;
        end
        if (step)
        begin
            res_reg      <= res;
            res_chan_reg <= res_chan;
        end
    end

    msas_core #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .CHANNEL_BITS (CHANNEL_BITS),
        .SYNC_PERIOD  (SYNC_PERIOD)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .op             (in_op_reg),
        .reply_ok       (in_ok_reg),
        .reply_value    (in_value_reg),
        .reply_channel  (in_chan_reg),
        .cfg            (cfg),
        .scan_list      (cfg_scan_reg),
        .res            (res),
        .sample_channel (res_chan)
    );

    // result beat
    assign out_valid      = out_vld_reg;
    assign next_command   = res_reg.cmd;
    assign sample_valid   = res_reg.sample_valid;
    assign sample_base    = res_reg.base_word;
    assign sample_hires   = res_reg.hires_word;
    assign sample_range   = res_reg.range_word;
    assign sample_channel = res_chan_reg;
    assign stopped        = res_reg.stopped;
    assign stop_reason    = res_reg.reason;

endmodule
